>>> src/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg
// shared types and constants of the alternating bit receiver
// ----------------------------------------------------------------------------
package abr_pkg;

  // default payload buffer depth per packet
  localparam int unsigned PayloadBytes = 20;

  // field widths that cover the full payload depth range (up to 64 bytes)
  localparam int unsigned CntW = 7;
  localparam int unsigned IdxW = 6;

  // configuration register indexes
  localparam logic [7:0] RegAckCode = 8'd0;
  localparam logic [7:0] RegSeqMax  = 8'd1;

  // register reset values
  localparam logic [15:0] AckCodeRst = 16'd1;
  localparam logic [7:0]  SeqMaxRst  = 8'd1;

  typedef enum logic {
    ResAck  = 1'b0,
    ResByte = 1'b1
  } res_type_e;

  // one command from the front to the back
  typedef struct packed {
    logic            deliver;  // ack followed by the buffered bytes
    logic [7:0]      seq;      // sequence number carried by the ack
    logic [CntW-1:0] cnt;      // number of buffered bytes
    logic            bank;     // payload bank holding the bytes
  } cmd_t;

  // payload buffer write port
  typedef struct packed {
    logic            en;
    logic            bank;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } wr_t;

  // status from the back to the front
  typedef struct packed {
    logic q_full;
    logic rel_valid;
    logic rel_bank;
  } bk_status_t;

endpackage

>>> src/alternating_bit_receiver_top.sv
// ----------------------------------------------------------------------------
// alternating_bit_receiver_top
// path to the output: command queue, sequencer stage, then the output register
// throughput: one input item per cycle, one result per cycle via the sequencer
// while results are popped; input stalls when the filling payload bank still
// waits to be delivered or the command queue is full; reset is asynchronous, active
// low, and clears all control state; the payload buffer holds no reset value
// ----------------------------------------------------------------------------
module alternating_bit_receiver_top #(
  parameter int unsigned PayloadBytes = abr_pkg::PayloadBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input item queue side
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] seq_num_i,
  input  logic signed [31:0] ack_num_i,
  input  logic signed [31:0] check_value_i,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_last_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic               result_type_o,
  output logic [7:0]         ack_seq_o,
  output logic [15:0]        ack_field_o,
  output logic [16:0]        ack_checksum_o,
  output logic [7:0]         out_byte_o,
  output logic               last_result_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // configuration registers
  logic [15:0] ack_code_q;
  logic [7:0]  seq_max_q;

  // front to back traffic
  abr_pkg::wr_t        wr;
  abr_pkg::cmd_t       cmd;
  logic                cmd_push;
  abr_pkg::bk_status_t status;

  // writes are taken every cycle; only idle-time writes are expected
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_code_q <= abr_pkg::AckCodeRst;
      seq_max_q  <= abr_pkg::SeqMaxRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abr_pkg::RegAckCode: ack_code_q <= cfg_data_i;
        abr_pkg::RegSeqMax:  seq_max_q  <= cfg_data_i[7:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // front: checksum, payload buffering and packet classification
  abr_front #(
    .PayloadBytes(PayloadBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seq_max_i    (seq_max_q),
    .push         (push),
    .full         (full),
    .seq_num_i    (seq_num_i),
    .ack_num_i    (ack_num_i),
    .check_value_i(check_value_i),
    .data_byte_i  (data_byte_i),
    .byte_last_i  (byte_last_i),
    .status_i     (status),
    .wr_o         (wr),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd)
  );

  // back: command queue, double-banked payload buffer, result sequencer
  abr_back #(
    .PayloadBytes(PayloadBytes)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ack_code_i    (ack_code_q),
    .wr_i          (wr),
    .cmd_push_i    (cmd_push),
    .cmd_i         (cmd),
    .status_o      (status),
    .empty         (empty),
    .pop           (pop),
    .result_type_o (result_type_o),
    .ack_seq_o     (ack_seq_o),
    .ack_field_o   (ack_field_o),
    .ack_checksum_o(ack_checksum_o),
    .out_byte_o    (out_byte_o),
    .last_result_o (last_result_o)
  );

endmodule

>>> src/abr_front.sv
// ----------------------------------------------------------------------------
// abr_front
// accepts payload items, keeps the checksum and classifies finished packets
// ----------------------------------------------------------------------------
module abr_front #(
  parameter int unsigned PayloadBytes = abr_pkg::PayloadBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          seq_max_i,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  seq_num_i,
  input  logic signed [31:0]  ack_num_i,
  input  logic signed [31:0]  check_value_i,
  input  logic [7:0]          data_byte_i,
  input  logic                byte_last_i,
  input  abr_pkg::bk_status_t status_i,
  output abr_pkg::wr_t        wr_o,
  output logic                cmd_push_o,
  output abr_pkg::cmd_t       cmd_o
);

  localparam int unsigned CW = $clog2(PayloadBytes + 1);

  logic [31:0]   sum_q, sum_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    exp_q, exp_d;
  logic [7:0]    last_ack_q, last_ack_d;
  logic          have_ack_q, have_ack_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;

  logic          accept;
  logic          buf_room;
  logic [31:0]   sum_new;
  logic [31:0]   total;
  logic [CW-1:0] idx_new;
  logic          good;
  logic          in_seq;
  logic [8:0]    exp_next;

  assign full     = status_i.q_full || busy_q[bank_q];
  assign accept   = push && !full;
  assign buf_room = idx_q < CW'(PayloadBytes);
  assign sum_new  = sum_q + {24'd0, data_byte_i};
  assign idx_new  = buf_room ? idx_q + CW'(1) : idx_q;
  assign total    = sum_new + $unsigned(seq_num_i) + $unsigned(ack_num_i);
  assign good     = total == $unsigned(check_value_i);
  assign in_seq   = $unsigned(seq_num_i) == {24'd0, exp_q};
  assign exp_next = {1'b0, exp_q} + 9'd1;

  // buffer write goes to the bank that is currently filling
  assign wr_o.en   = accept && buf_room;
  assign wr_o.bank = bank_q;
  assign wr_o.idx  = abr_pkg::IdxW'(idx_q);
  assign wr_o.data = data_byte_i;

  assign cmd_push_o  = accept && byte_last_i && good && (in_seq || have_ack_q);
  assign cmd_o.deliver = in_seq;
  assign cmd_o.seq     = in_seq ? exp_q : last_ack_q;
  assign cmd_o.cnt     = abr_pkg::CntW'(idx_new);
  assign cmd_o.bank    = bank_q;

  always_comb begin
    sum_d      = sum_q;
    idx_d      = idx_q;
    exp_d      = exp_q;
    last_ack_d = last_ack_q;
    have_ack_d = have_ack_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    if (status_i.rel_valid) begin
      busy_d[status_i.rel_bank] = 1'b0;
    end
    if (accept) begin
      if (byte_last_i) begin
        sum_d = '0;
        idx_d = '0;
        if (good && in_seq) begin
          last_ack_d     = exp_q;
          have_ack_d     = 1'b1;
          exp_d          = (exp_next > {1'b0, seq_max_i}) ? 8'd0 : exp_next[7:0];
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
        end
      end else begin
        sum_d = sum_new;
        idx_d = idx_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      idx_q      <= '0;
      exp_q      <= '0;
      last_ack_q <= '0;
      have_ack_q <= 1'b0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      sum_q      <= sum_d;
      idx_q      <= idx_d;
      exp_q      <= exp_d;
      last_ack_q <= last_ack_d;
      have_ack_q <= have_ack_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

endmodule

>>> src/abr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// abr_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module abr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  abr_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output abr_pkg::cmd_t data_o
);

  abr_pkg::cmd_t ent_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> src/abr_back.sv
// ----------------------------------------------------------------------------
// abr_back
// payload buffer and result sequencer: ack first, then the buffered bytes
// ----------------------------------------------------------------------------
module abr_back #(
  parameter int unsigned PayloadBytes = abr_pkg::PayloadBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         ack_code_i,
  input  abr_pkg::wr_t        wr_i,
  input  logic                cmd_push_i,
  input  abr_pkg::cmd_t       cmd_i,
  output abr_pkg::bk_status_t status_o,
  output logic                empty,
  input  logic                pop,
  output logic                result_type_o,
  output logic [7:0]          ack_seq_o,
  output logic [15:0]         ack_field_o,
  output logic [16:0]         ack_checksum_o,
  output logic [7:0]          out_byte_o,
  output logic                last_result_o
);

  localparam int unsigned CW = $clog2(PayloadBytes + 1);
  localparam int unsigned IW = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;

  logic [7:0] mem_q [2][PayloadBytes];
  logic [7:0] rd_data_q;

  abr_pkg::cmd_t head;
  logic          head_valid;
  logic          q_full;
  logic          q_pop;

  logic [CW-1:0] pos_q;
  logic [CW-1:0] head_cnt;
  logic [IW-1:0] rd_idx;
  logic          is_ack;
  logic          issue;
  logic          issue_last;

  logic               s1_valid_q;
  abr_pkg::res_type_e s1_type_q;
  logic               s1_last_q;
  logic [7:0]         s1_seq_q;
  logic               s1_move;

  logic out_valid_q;

  abr_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push_i),
    .data_i (cmd_i),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(head_valid),
    .data_o (head)
  );

  assign head_cnt   = CW'(head.cnt);
  assign is_ack     = pos_q == '0;
  assign rd_idx     = IW'(pos_q - CW'(1));
  assign s1_move    = s1_valid_q && (!out_valid_q || pop);
  assign issue      = head_valid && (!s1_valid_q || s1_move);
  assign issue_last = is_ack ? !head.deliver : (pos_q == head_cnt);
  assign q_pop      = issue && issue_last;

  assign status_o.q_full    = q_full;
  assign status_o.rel_valid = q_pop && head.deliver;
  assign status_o.rel_bank  = head.bank;

  assign empty = !out_valid_q;

  // payload buffer, read data registered on each byte issue
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][IW'(wr_i.idx)] <= wr_i.data;
    end
    if (issue && !is_ack) begin
      rd_data_q <= mem_q[head.bank][rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        pos_q <= issue_last ? '0 : pos_q + CW'(1);
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_type_q <= is_ack ? abr_pkg::ResAck : abr_pkg::ResByte;
      s1_last_q <= issue_last;
      s1_seq_q  <= head.seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      result_type_o <= s1_type_q;
      last_result_o <= s1_last_q;
      if (s1_type_q == abr_pkg::ResAck) begin
        ack_seq_o      <= s1_seq_q;
        ack_field_o    <= ack_code_i;
        ack_checksum_o <= {9'd0, s1_seq_q} + {1'b0, ack_code_i};
        out_byte_o     <= '0;
      end else begin
        ack_seq_o      <= '0;
        ack_field_o    <= '0;
        ack_checksum_o <= '0;
        out_byte_o     <= rd_data_q;
      end
    end
  end

  // front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push_i |-> !q_full)
    else $error("command pushed into full queue");

  // a byte is issued only for a command that delivers payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !is_ack) |-> head.deliver)
    else $error("byte issued for ack-only command");

  // sequencer returns to the ack slot after the final result of a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && issue_last) |=> (pos_q == '0))
    else $error("sequencer position not cleared after command");

  // a byte position never runs past the buffered count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && !is_ack) |-> (pos_q <= head_cnt))
    else $error("byte position beyond buffered count");

endmodule
